@@ design/lbp_pkg.sv @@
// Package for the 3x3 local binary pattern stream block.
// Holds line store sizing, register indexes and the gray conversion.
// No dependencies.
package lbp_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int FW_W      = 12;
    localparam int FH_W      = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int FIFO_DEPTH = 3;

    localparam logic [FW_W-1:0] FW_RESET = 12'd640;
    localparam logic [FH_W-1:0] FH_RESET = 16'd480;
    localparam logic [FW_W-1:0] FW_MIN   = 12'd3;
    localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FH_MIN   = 16'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 8'd0,
        REG_FRAME_HEIGHT = 8'd1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] lbp_code;
        logic       frame_end;
    } t_result;

    function automatic logic [7:0] to_gray(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r);
        logic [21:0] y;
        y = 22'(r) * 22'd4899 + 22'(g) * 22'd9617 + 22'(b) * 22'd1868 + 22'd8192;
        return y[21:14];
    endfunction

endpackage

@@ design/lbp_pix_if.sv @@
// Pixel request channel: valid/ready with BGR payload.
// Depends on nothing.
interface lbp_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;

    modport source (output valid, pixel_blue, pixel_green, pixel_red, input ready);
    modport sink   (input valid, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

@@ design/lbp_code_if.sv @@
// Result request channel: valid/ready with pattern code and frame end flag.
// Depends on nothing.
interface lbp_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] lbp_code;
    logic       frame_end;

    modport source (output valid, lbp_code, frame_end, input ready);
    modport sink   (input valid, lbp_code, frame_end, output ready);
endinterface

@@ design/lbp_cfg_if.sv @@
// Configuration write channel: valid/ready with register index and data.
// Depends on lbp_pkg for field widths.
interface lbp_cfg_if;
    import lbp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/lbp_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ design/lbp_3x3_code_stream.sv @@
// 3x3 local binary pattern over a raster BGR stream; top level.
// A code passes from the stage-one registers into the result queue once the pixel below-right of its center is taken.
// Throughput: 1 pixel per cycle if the queue has room; read at accept, written next cycle.
// Reset: registers go to 640x480, counters to the frame start; line stores keep contents.
// Depends on lbp_pkg, lbp_pix_if, lbp_code_if, lbp_cfg_if and lbp_ram.
module lbp_3x3_code_stream
    import lbp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    lbp_pix_if.sink    i_pix,
    lbp_cfg_if.sink    i_cfg,
    lbp_code_if.source o_code
);
    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic [FW_W-1:0]  eff_w;
    logic [FH_W-1:0]  eff_h;
    logic [COL_W-1:0] r_col, n_col;
    logic [FH_W-1:0]  r_row, n_row;
    logic             cfg_wr, cfg_hit, pix_acc;
    logic             last_col, last_row;

    logic             r_s1_valid;
    logic [7:0]       r_s1_gray;
    logic [COL_W-1:0] r_s1_idx;
    logic             r_s1_emit;
    logic             r_s1_end;

    logic [7:0]       top, mid;
    logic [7:0]       r_win [6];
    t_result          res;

    t_result          r_fifo [FIFO_DEPTH];
    logic [1:0]       r_wr_ptr, r_rd_ptr, r_cnt, n_cnt;
    logic             push, pop;
    logic [2:0]       pending;

    // effective geometry
    always_comb begin
        eff_w = r_frame_width;
        if (r_frame_width < FW_MIN) begin
            eff_w = FW_MIN;
        end else if (r_frame_width > FW_MAX) begin
            eff_w = FW_MAX;
        end
        eff_h = (r_frame_height < FH_MIN) ? FH_MIN : r_frame_height;
    end

    assign i_cfg.ready = 1'b1;
    assign cfg_wr  = i_cfg.valid && i_cfg.ready;
    assign cfg_hit = cfg_wr && (i_cfg.index == REG_FRAME_WIDTH ||
                                i_cfg.index == REG_FRAME_HEIGHT);

    assign pending     = 3'(r_cnt) + 3'(r_s1_valid);
    assign i_pix.ready = pending < 3'(FIFO_DEPTH);
    assign pix_acc     = i_pix.valid && i_pix.ready;

    assign last_col = ((FW_W)'(r_col) + 12'd1) >= eff_w;
    assign last_row = ({1'b0, r_row} + 17'd1) >= {1'b0, eff_h};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
        end else if (cfg_wr) begin
            unique case (i_cfg.index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg.data[FW_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg.data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // raster position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (pix_acc) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 16'd1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= pix_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_gray <= to_gray(i_pix.pixel_blue, i_pix.pixel_green, i_pix.pixel_red);
            r_s1_idx  <= r_col;
            r_s1_emit <= (r_row >= 16'd2) && (r_col >= COL_W'(2));
            r_s1_end  <= last_col && last_row;
        end
    end

    lbp_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_row_older (
        .i_clk    (i_clk),
        .i_wr_en  (r_s1_valid),
        .i_wr_addr(r_s1_idx),
        .i_wr_data(mid),
        .i_rd_en  (pix_acc),
        .i_rd_addr(r_col),
        .o_rd_data(top)
    );

    lbp_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_row_newer (
        .i_clk    (i_clk),
        .i_wr_en  (r_s1_valid),
        .i_wr_addr(r_s1_idx),
        .i_wr_data(r_s1_gray),
        .i_rd_en  (pix_acc),
        .i_rd_addr(r_col),
        .o_rd_data(mid)
    );

    // compare center against its eight neighbors
    always_comb begin
        res.lbp_code[7] = r_win[4] >= r_win[0];
        res.lbp_code[6] = r_win[4] >= r_win[1];
        res.lbp_code[5] = r_win[4] >= r_win[2];
        res.lbp_code[4] = r_win[4] >= r_win[5];
        res.lbp_code[3] = r_win[4] >= r_s1_gray;
        res.lbp_code[2] = r_win[4] >= mid;
        res.lbp_code[1] = r_win[4] >= top;
        res.lbp_code[0] = r_win[4] >= r_win[3];
        res.frame_end   = r_s1_end;
    end

    // advance the window
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= top;
            r_win[4] <= mid;
            r_win[5] <= r_s1_gray;
        end
    end

    // result queue
    assign push = r_s1_valid && r_s1_emit;
    assign pop  = o_code.valid && o_code.ready;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == 2'(FIFO_DEPTH - 1)) ? 2'd0 : r_wr_ptr + 2'd1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == 2'(FIFO_DEPTH - 1)) ? 2'd0 : r_rd_ptr + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    assign o_code.valid     = r_cnt != 2'd0;
    assign o_code.lbp_code  = r_fifo[r_rd_ptr].lbp_code;
    assign o_code.frame_end = r_fifo[r_rd_ptr].frame_end;
endmodule

@@ test/lbp_3x3_code_stream_tb.sv @@
`timescale 1ns / 100ps
// Testbench for lbp_3x3_code_stream: streams BGR frames under several geometries,
// predicts every pattern code and checks each result request in order.
// Depends on lbp_pkg, lbp_pix_if, lbp_cfg_if, lbp_code_if and the block itself.
module lbp_3x3_code_stream_tb;
    import lbp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 8'hFF;
    localparam int DRAIN_CYCLES   = 8;
    localparam int DEFAULT_PIXELS = 64;
    localparam int WIDE_PIXELS    = 24;
    localparam int RANDOM_PIXELS  = 860;
    localparam int MAX_REPORTS    = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lbp_pix_if  pix_if();
    lbp_cfg_if  cfg_if();
    lbp_code_if code_if();

    lbp_3x3_code_stream dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_code  (code_if)
    );

    always #10 i_clk = ~i_clk;

    logic [FW_W-1:0] cfg_width;
    logic [FH_W-1:0] cfg_height;
    logic [7:0]      older_line [MAX_WIDTH];
    logic [7:0]      newer_line [MAX_WIDTH];
    logic [7:0]      window [6];
    int unsigned     col_pos;
    int unsigned     row_pos;
    t_result         pending_codes [$];
    int              error_count = 0;
    bit              src_gaps;
    bit              sink_gaps;
    bit              palette_on;
    logic [23:0]     palette [4];

    function automatic int unsigned active_width();
        int unsigned w;
        w = cfg_width;
        if (w < 3) w = 3;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = cfg_height;
        if (h < 3) h = 3;
        return h;
    endfunction

    function automatic void predict_lbp(input logic [23:0] bgr);
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        int unsigned luma;
        logic [7:0]  gray;
        logic [7:0]  top;
        logic [7:0]  mid;
        logic [7:0]  ctr;
        t_result     res;
        w    = active_width();
        h    = active_height();
        idx  = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
        luma = (4899 * int'(bgr[7:0]) + 9617 * int'(bgr[15:8])
                + 1868 * int'(bgr[23:16]) + 8192) >> 14;
        gray = 8'(luma);
        top  = older_line[idx];
        mid  = newer_line[idx];
        older_line[idx] = mid;
        newer_line[idx] = gray;
        if (row_pos >= 2 && col_pos >= 2) begin
            ctr = window[4];
            res.lbp_code  = {ctr >= window[0], ctr >= window[1], ctr >= window[2],
                             ctr >= window[5], ctr >= gray, ctr >= mid, ctr >= top,
                             ctr >= window[3]};
            res.frame_end = (col_pos + 1 >= w) && (row_pos + 1 >= h);
            pending_codes = {pending_codes, res};
        end
        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = top;
        window[4] = mid;
        window[5] = gray;
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DAT_W-1:0] data);
        if (idx == REG_FRAME_WIDTH) begin
            cfg_width = data[FW_W-1:0];
        end else if (idx == REG_FRAME_HEIGHT) begin
            cfg_height = data[FH_W-1:0];
        end else begin
            return;
        end
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic int pick_gap(input bit enabled);
        int roll;
        if (!enabled) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_extent(input int typ_hi, input int far_hi);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return $urandom_range(0, 2);
        if (roll < 85) return $urandom_range(3, typ_hi);
        return $urandom_range(typ_hi + 1, far_hi);
    endfunction

    function automatic logic [23:0] draw_pixel();
        if (palette_on) return palette[$urandom_range(0, 3)];
        return 24'($urandom);
    endfunction

    task automatic choose_traffic();
        src_gaps   = ($urandom_range(0, 3) != 0);
        sink_gaps  = ($urandom_range(0, 3) != 0);
        palette_on = $urandom_range(0, 1);
        foreach (palette[i]) palette[i] = 24'($urandom);
    endtask

    task automatic send_pixel(input logic [23:0] bgr);
        int gap;
        gap = pick_gap(src_gaps);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_blue  <= bgr[23:16];
        pix_if.pixel_green <= bgr[15:8];
        pix_if.pixel_red   <= bgr[7:0];
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        predict_lbp(bgr);
    endtask

    task automatic send_pixels(input int count);
        repeat (count) send_pixel(draw_pixel());
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        apply_register(idx, data);
    endtask

    task automatic configure(input logic [CFG_DAT_W-1:0] w_data,
                             input logic [CFG_DAT_W-1:0] h_data, input bit with_spare);
        write_register(REG_FRAME_WIDTH, w_data);
        if (with_spare)
            write_register(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                           CFG_DAT_W'($urandom));
        write_register(REG_FRAME_HEIGHT, h_data);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_default_geometry();
        choose_traffic();
        send_pixels(DEFAULT_PIXELS);
        wait_idle();
    endtask

    task automatic test_pixel_extremes();
        logic [23:0] corners [9];
        logic [23:0] flat;
        corners = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'h808080,
                    24'hFF0000, 24'h00FFFF, 24'h808080, 24'hFF00FF};
        src_gaps  = 1'b0;
        sink_gaps = 1'b1;
        configure(16'hF000, 16'd2, 1'b0);
        foreach (corners[i]) send_pixel(corners[i]);
        wait_idle();
        // hold a flat frame across writes to unused indexes
        flat = 24'($urandom);
        repeat (5) send_pixel(flat);
        wait_idle();
        write_register(REG_SPARE_FIRST, 16'hFFFF);
        write_register(REG_SPARE_LAST, 16'h0000);
        cfg_if.valid <= 1'b0;
        repeat (4) send_pixel(flat);
        wait_idle();
    endtask

    task automatic test_widest_frames();
        choose_traffic();
        configure(16'h0FFF, 16'd3, 1'b0);
        send_pixels(WIDE_PIXELS);
        wait_idle();
        choose_traffic();
        configure(16'h5800, 16'd0, 1'b1);
        send_pixels(WIDE_PIXELS);
        wait_idle();
    endtask

    task automatic test_tallest_frame();
        choose_traffic();
        configure(16'd3, 16'hFFFF, 1'b0);
        send_pixels(60);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int                   sent;
        int                   pixels;
        logic [CFG_DAT_W-1:0] w_data;
        logic [CFG_DAT_W-1:0] h_data;
        sent   = 0;
        w_data = 16'd5;
        h_data = 16'd4;
        while (sent < RANDOM_PIXELS) begin
            choose_traffic();
            if ($urandom_range(0, 4) != 0) begin
                w_data = {4'($urandom), 12'(pick_extent(12, 48))};
                h_data = 16'(pick_extent(7, 16));
            end
            configure(w_data, h_data, $urandom_range(0, 7) == 0);
            pixels = active_width() * active_height() * $urandom_range(1, 2);
            // drop out mid-frame now and then
            if ($urandom_range(0, 3) == 0) pixels = $urandom_range(1, pixels - 1);
            if (pixels > RANDOM_PIXELS - sent) pixels = RANDOM_PIXELS - sent;
            send_pixels(pixels);
            sent += pixels;
            wait_idle();
        end
    endtask

    initial begin
        int      stall_left;
        t_result want;
        stall_left = 0;
        code_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && code_if.valid && code_if.ready) begin
                if (pending_codes.size() == 0) begin
                    if (error_count < MAX_REPORTS)
                        $display("unexpected code %02h end %0b", code_if.lbp_code,
                                 code_if.frame_end);
                    error_count++;
                end else begin
                    want = pending_codes.pop_front();
                    if (code_if.lbp_code !== want.lbp_code
                            || code_if.frame_end !== want.frame_end) begin
                        if (error_count < MAX_REPORTS)
                            $display("code mismatch: expected %02h end %0b, got %02h end %0b",
                                     want.lbp_code, want.frame_end, code_if.lbp_code,
                                     code_if.frame_end);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0) stall_left--;
            else stall_left = pick_gap(sink_gaps);
            code_if.ready <= (stall_left == 0);
        end
    end

    initial begin
        i_rst_n            <= 1'b0;
        pix_if.valid       <= 1'b0;
        pix_if.pixel_blue  <= 8'd0;
        pix_if.pixel_green <= 8'd0;
        pix_if.pixel_red   <= 8'd0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= '0;
        cfg_if.data        <= '0;
        cfg_width  = FW_RESET;
        cfg_height = FH_RESET;
        col_pos    = 0;
        row_pos    = 0;
        foreach (older_line[i]) begin
            older_line[i] = 8'd0;
            newer_line[i] = 8'd0;
        end
        foreach (window[i]) window[i] = 8'd0;
        src_gaps   = 1'b0;
        sink_gaps  = 1'b0;
        palette_on = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_geometry();
        test_pixel_extremes();
        test_widest_frames();
        test_tallest_frame();
        test_random_frames();
        wait_idle();

        if (error_count == 0 && pending_codes.size() == 0) begin
            $display("[lbp_3x3_code_stream] OK");
        end else begin
            $display("[lbp_3x3_code_stream] ERROR");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("[lbp_3x3_code_stream] ERROR");
        $finish;
    end

endmodule

@@ lbp_3x3_code_stream.f @@
design/lbp_pkg.sv
design/lbp_pix_if.sv
design/lbp_code_if.sv
design/lbp_cfg_if.sv
design/lbp_ram.sv
design/lbp_3x3_code_stream.sv
test/lbp_3x3_code_stream_tb.sv
